[sv/lpht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, types and helpers of the linear-probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   // Table geometry.
   localparam int TABLE_SIZE = 16;
   localparam int KEY_BYTES  = 8;
   localparam int KEY_W      = 64;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);

   // Home slot arithmetic: byte sum reduced by a reciprocal multiply.
   localparam int SUM_W    = $clog2(KEY_BYTES * 255 + 1);
   localparam int RECIP_SH = 24;
   localparam int RECIP_W  = RECIP_SH;
   localparam int RECIP    = (2 ** RECIP_SH + TABLE_SIZE - 1) / TABLE_SIZE;
   localparam int QUO_W    = SUM_W;
   localparam int TS_W     = $clog2(TABLE_SIZE + 1);

   // Result slot field and zero extension of a slot index to reach it.
   localparam int SLOT_OUT_W = 4;
   localparam int POS_EXT_W  = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;

   // Stream widths.
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 8;

   // Operation codes.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_USED    = 2'd1,
      SLOT_DELETED = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      RES_OK      = 2'd0,
      RES_MISSING = 2'd1,
      RES_FULL    = 2'd2
   } status_type;

   // One table entry as held in the memory.
   typedef struct packed {
      slot_state_type       state;
      logic [KEY_W-1:0]     key;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Hash unit result handed to the probe controller.
   typedef struct packed {
      logic                 valid;
      logic [KEY_W-1:0]     key;
      logic [SLOT_W-1:0]    home;
   } hash_out_type;

   // Low bits of a slot index as carried in the result item.
   function automatic logic [SLOT_OUT_W-1:0] slot_field(input logic [SLOT_W-1:0] pos);
      logic [POS_EXT_W-1:0] ext;
      ext = POS_EXT_W'(pos);
      return ext[SLOT_OUT_W-1:0];
   endfunction

endpackage
`default_nettype wire

[sv/lpht_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on request, read the addressed entry every cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/lpht_hash.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_hash
// Key normalization and home slot computation, three register stages.
// ----------------------------------------------------------------------------
module lpht_hash (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [lpht_pkg::KEY_W-1:0]  in_key,
   output lpht_pkg::hash_out_type           hash_out
);
   import lpht_pkg::*;

   localparam int PROD_W = SUM_W + RECIP_W;
   localparam int REM_W  = QUO_W + TS_W;

   logic [KEY_W-1:0]  norm_key;
   logic [SUM_W-1:0]  byte_sum;
   logic [PROD_W-1:0] quo_prod;
   logic [REM_W-1:0]  rem_full;

   logic              v1_ff, v1_in;
   logic [KEY_W-1:0]  key1_ff;
   logic [SUM_W-1:0]  sum1_ff;
   logic              v2_ff, v2_in;
   logic [KEY_W-1:0]  key2_ff;
   logic [SUM_W-1:0]  sum2_ff;
   logic [QUO_W-1:0]  quo2_ff, quo2_in;
   logic              v3_ff, v3_in;
   logic [KEY_W-1:0]  key3_ff;
   logic [SLOT_W-1:0] home3_ff, home3_in;

   // The key ends at its first zero byte or after KEY_BYTES bytes.
   always_comb begin
      logic       keep;
      logic [7:0] b;
      keep     = 1'b1;
      norm_key = '0;
      byte_sum = '0;
      for (int i = 0; i < 8; i++) begin
         b = in_key[8*i +: 8];
         if ((i >= KEY_BYTES) || (b == 8'd0)) begin
            keep = 1'b0;
         end
         if (keep) begin
            norm_key[8*i +: 8] = b;
            byte_sum           = byte_sum + SUM_W'(b);
         end
      end
   end

   // Quotient of the byte sum by the table size, via reciprocal multiply.
   always_comb begin
      quo_prod = PROD_W'(sum1_ff) * PROD_W'(RECIP);
      quo2_in  = QUO_W'(quo_prod >> RECIP_SH);
   end

   // Remainder; the reciprocal is exact over the byte sum range.
   always_comb begin
      rem_full = REM_W'(sum2_ff) - REM_W'(quo2_ff) * REM_W'(TABLE_SIZE);
      home3_in = SLOT_W'(rem_full);
   end

   assign v1_in = in_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      key1_ff  <= norm_key;
      sum1_ff  <= byte_sum;
      key2_ff  <= key1_ff;
      sum2_ff  <= sum1_ff;
      quo2_ff  <= quo2_in;
      key3_ff  <= key2_ff;
      home3_ff <= home3_in;
   end

   assign hash_out.valid = v3_ff;
   assign hash_out.key   = key3_ff;
   assign hash_out.home  = home3_ff;

endmodule
`default_nettype wire

[sv/lpht_probe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_probe
// Probe sequencer: clears the table after reset, walks slots from the home
// slot through the entry memory and holds the result item register.
// ----------------------------------------------------------------------------
module lpht_probe (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [1:0]                    req_mode,
   input  wire lpht_pkg::hash_out_type        hash_out,
   output logic                               ram_wr_en,
   output logic [lpht_pkg::SLOT_W-1:0]        ram_addr,
   output logic [lpht_pkg::ENTRY_W-1:0]       ram_wr_data,
   input  wire logic [lpht_pkg::ENTRY_W-1:0]  ram_rd_data,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [lpht_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import lpht_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_CHECK,
      ST_RESP
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

   state_type              state_ff, state_in;
   logic [1:0]             mode_ff, mode_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [SLOT_W-1:0]      pos_ff, pos_in;
   logic [SLOT_W-1:0]      cnt_ff, cnt_in;
   logic [SLOT_W-1:0]      clr_ff, clr_in;
   status_type             res_status_ff, res_status_in;
   logic [SLOT_OUT_W-1:0]  res_slot_ff, res_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;

   entry_type              rd_entry;
   entry_type              wr_entry;
   logic [SLOT_W-1:0]      pos_nx;
   logic                   last_probe;
   logic                   is_insert;
   logic                   is_remove;

   assign rd_entry   = entry_type'(ram_rd_data);
   assign pos_nx     = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;
   assign last_probe = (cnt_ff == LAST_SLOT);
   assign is_insert  = (mode_ff == OP_INSERT);
   assign is_remove  = (mode_ff == OP_REMOVE);

   // Next-state and memory control.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      ram_wr_en     = 1'b0;
      ram_addr      = pos_ff;
      wr_entry      = '{state: SLOT_EMPTY, key: '0};

      unique case (state_ff)
         // Sweep every slot to empty after reset.
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            ram_addr  = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_mode;
               state_in = ST_HASH;
            end
         end
         // Wait for the home slot, then read it.
         ST_HASH: begin
            ram_addr = hash_out.home;
            if (hash_out.valid) begin
               key_in   = hash_out.key;
               pos_in   = hash_out.home;
               cnt_in   = '0;
               state_in = ST_CHECK;
            end
         end
         // Examine the entry at pos_ff; read the next slot when moving on.
         ST_CHECK: begin
            if (is_insert) begin
               if (rd_entry.state != SLOT_USED) begin
                  ram_wr_en     = 1'b1;
                  wr_entry      = '{state: SLOT_USED, key: key_ff};
                  res_status_in = RES_OK;
                  res_slot_in   = slot_field(pos_ff);
                  state_in      = ST_RESP;
               end else if (last_probe) begin
                  res_status_in = RES_FULL;
                  res_slot_in   = '0;
                  state_in      = ST_RESP;
               end else begin
                  pos_in   = pos_nx;
                  cnt_in   = cnt_ff + 1'b1;
                  ram_addr = pos_nx;
               end
            end else begin
               if (rd_entry.state == SLOT_EMPTY) begin
                  res_status_in = RES_MISSING;
                  res_slot_in   = '0;
                  state_in      = ST_RESP;
               end else if ((rd_entry.state == SLOT_USED) && (rd_entry.key == key_ff)) begin
                  res_status_in = RES_OK;
                  res_slot_in   = slot_field(pos_ff);
                  state_in      = ST_RESP;
                  if (is_remove) begin
                     ram_wr_en = 1'b1;
                     wr_entry  = '{state: SLOT_DELETED, key: key_ff};
                  end
               end else if (last_probe) begin
                  res_status_in = RES_MISSING;
                  res_slot_in   = '0;
                  state_in      = ST_RESP;
               end else begin
                  pos_in   = pos_nx;
                  cnt_in   = cnt_ff + 1'b1;
                  ram_addr = pos_nx;
               end
            end
         end
         // Hand the result to the output register once it is free.
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ram_wr_data = ENTRY_W'(wr_entry);

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_slot_ff, rsp_status_ff});

endmodule
`default_nettype wire

[sv/linear_probe_hash_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing and tombstones.
//
//   Channel  Direction  Item contents (low bit first)
//   req_     in         mode[1:0], key[65:2], zero pad [71:66]
//   rsp_     out        status[1:0], slot[5:2], zero pad [7:6]
//
// One item at a time: the key passes the hash unit stages, then each probed
// slot (at most TABLE_SIZE) is read on the single entry memory port, then
// the result register is loaded, and only after that is the next item
// taken. After reset every slot is cleared to empty, one slot a cycle,
// before the first item is taken. A result held by a stalled rsp_ side
// blocks the next item only once that item's result is ready.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // mode[1:0], key[65:2], zero pad
   input  wire logic [lpht_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // status[1:0], slot[5:2], zero pad
   output logic [lpht_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);
   import lpht_pkg::*;

   hash_out_type         hash_out;
   logic                 req_fire;
   logic                 ram_wr_en;
   logic [SLOT_W-1:0]    ram_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic [ENTRY_W-1:0]   ram_rd_data;

   assign req_fire = req_tvalid && req_tready;

   // Normalize the key and find its home slot.
   lpht_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_fire),
      .in_key   (req_tdata[KEY_W+1:2]),
      .hash_out (hash_out)
   );

   // Probe sequencer and result register.
   lpht_probe u_probe (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_mode    (req_tdata[1:0]),
      .hash_out    (hash_out),
      .ram_wr_en   (ram_wr_en),
      .ram_addr    (ram_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_data (ram_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // Entry memory: slot state and stored key side by side.
   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire
